// File: rtl/brle_pkg.sv
// shared types and constants of the byte run-length encoder
package brle_pkg;

    localparam int unsigned CAP_W       = 20;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]       RUN_MAX    = 8'd255;
    localparam logic [CAP_W:0]   PAIR_BYTES = 21'd2;

    // one pair to be emitted
    typedef struct packed {
        logic [7:0] count;
        logic [7:0] value;
        logic       last;
    } t_cmd;

    // up to two pairs pushed by one source word, first then second
    typedef struct packed {
        logic a_vld;
        t_cmd a;
        logic b_vld;
        t_cmd b;
    } t_push;

endpackage

// File: rtl/brle_front.sv
// run tracking: turns source words into pair commands
module brle_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    output brle_pkg::t_push o_push
);

    logic       r_run_open;
    logic [7:0] r_open_value;
    logic [7:0] r_open_count;

    logic       n_run_open;
    logic [7:0] n_open_value;
    logic [7:0] n_open_count;

    logic       extend;
    logic [7:0] new_count;
    logic       close_new;

    always_comb begin
        extend    = r_run_open && (i_data_byte == r_open_value);
        new_count = extend ? (r_open_count + 8'd1) : 8'd1;
        close_new = (new_count == brle_pkg::RUN_MAX) || i_last_byte;

        o_push.a_vld   = i_accept && r_run_open && !extend;
        o_push.a.count = r_open_count;
        o_push.a.value = r_open_value;
        o_push.a.last  = 1'b0;
        o_push.b_vld   = i_accept && close_new;
        o_push.b.count = new_count;
        o_push.b.value = i_data_byte;
        o_push.b.last  = i_last_byte;

        n_run_open   = r_run_open;
        n_open_value = r_open_value;
        n_open_count = r_open_count;
        if (i_accept) begin
            if (close_new) begin
                n_run_open   = 1'b0;
                n_open_value = 8'd0;
                n_open_count = 8'd0;
            end else begin
                n_run_open   = 1'b1;
                n_open_value = i_data_byte;
                n_open_count = new_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open   <= 1'b0;
            r_open_value <= 8'd0;
            r_open_count <= 8'd0;
        end else begin
            r_run_open   <= n_run_open;
            r_open_value <= n_open_value;
            r_open_count <= n_open_count;
        end
    end

endmodule

// File: rtl/brle_queue.sv
// short command queue, two pushes and one pop per cycle
module brle_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  brle_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_head_vld,
    output brle_pkg::t_cmd  o_head,
    output logic            o_full
);

    brle_pkg::t_cmd r_mem [brle_pkg::QUEUE_DEPTH];

    logic [brle_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [brle_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [brle_pkg::QCNT_W-1:0] r_count;

    logic [brle_pkg::QPTR_W-1:0] n_wr_ptr;
    logic [brle_pkg::QPTR_W-1:0] n_rd_ptr;
    logic [brle_pkg::QCNT_W-1:0] n_count;

    logic [brle_pkg::QPTR_W-1:0] b_ptr;
    logic [brle_pkg::QCNT_W-1:0] push_n;
    logic [brle_pkg::QCNT_W-1:0] pop_n;

    always_comb begin
        push_n   = brle_pkg::QCNT_W'(i_push.a_vld) + brle_pkg::QCNT_W'(i_push.b_vld);
        pop_n    = brle_pkg::QCNT_W'(i_pop);
        b_ptr    = i_push.a_vld ? (r_wr_ptr + brle_pkg::QPTR_W'(1)) : r_wr_ptr;
        n_wr_ptr = r_wr_ptr + brle_pkg::QPTR_W'(push_n);
        n_rd_ptr = r_rd_ptr + brle_pkg::QPTR_W'(pop_n);
        n_count  = r_count + push_n - pop_n;
    end

    assign o_head_vld = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    // room for two commands from the next word
    assign o_full     = (r_count > brle_pkg::QCNT_W'(brle_pkg::QUEUE_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.a_vld) begin
            r_mem[r_wr_ptr] <= i_push.a;
        end
        if (i_push.b_vld) begin
            r_mem[b_ptr] <= i_push.b;
        end
    end

endmodule

// File: rtl/brle_back.sv
// capacity check, failure handling and output register
module brle_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [brle_pkg::CAP_W-1:0] i_out_capacity,
    input  logic                       i_head_vld,
    input  brle_pkg::t_cmd             i_head,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_run_count,
    output logic [7:0]                 o_run_value,
    output logic                       o_overflow,
    output logic                       o_last_run,
    output logic [brle_pkg::CAP_W-1:0] o_bytes_written
);

    logic [brle_pkg::CAP_W-1:0] r_capacity;
    logic [brle_pkg::CAP_W-1:0] r_written;
    logic                       r_failed;
    logic                       r_out_valid;
    logic [7:0]                 r_run_count;
    logic [7:0]                 r_run_value;
    logic                       r_overflow;
    logic                       r_last_run;
    logic [brle_pkg::CAP_W-1:0] r_bytes_written;

    logic [brle_pkg::CAP_W-1:0] n_written;
    logic                       n_failed;
    logic                       n_out_valid;

    logic                       out_free;
    logic                       emit;
    logic [brle_pkg::CAP_W:0]   sum;
    logic                       ovf;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        sum      = {1'b0, r_written} + brle_pkg::PAIR_BYTES;
        ovf      = (sum > {1'b0, r_capacity});
        o_pop    = i_head_vld && (r_failed || out_free);
        emit     = i_head_vld && !r_failed && out_free;

        n_written   = r_written;
        n_failed    = r_failed;
        n_out_valid = r_out_valid && i_out_stall;
        if (o_pop) begin
            if (r_failed) begin
                // swallow until the end of the block
                if (i_head.last) begin
                    n_failed  = 1'b0;
                    n_written = '0;
                end
            end else begin
                n_out_valid = 1'b1;
                if (ovf) begin
                    n_written = '0;
                    n_failed  = !i_head.last;
                end else if (i_head.last) begin
                    n_written = '0;
                end else begin
                    n_written = sum[brle_pkg::CAP_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= '1;
            r_written   <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_out_capacity;
            end
            r_written   <= n_written;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_run_count     <= ovf ? 8'd0 : i_head.count;
            r_run_value     <= ovf ? 8'd0 : i_head.value;
            r_overflow      <= ovf;
            r_last_run      <= ovf ? 1'b1 : i_head.last;
            r_bytes_written <= ovf ? '0 : sum[brle_pkg::CAP_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_run_count     = r_run_count;
    assign o_run_value     = r_run_value;
    assign o_overflow      = r_overflow;
    assign o_last_run      = r_last_run;
    assign o_bytes_written = r_bytes_written;

endmodule

// File: rtl/byte_run_length_encoder_top.sv
// top level of the byte run-length encoder
//
// channel   direction  handshake                  payload
// source    in         i_in_valid / o_in_stall    i_data_byte, i_last_byte
// pairs     out        o_out_valid / i_out_stall  o_run_count, o_run_value, o_overflow,
//                                                 o_last_run, o_bytes_written
// config    in         i_cfg_valid / o_cfg_ready  i_out_capacity
//
// one source word per cycle while o_in_stall is low; a closed pair passes the queue, then the output register
// the front tracks the open run, a four-entry queue holds pairs, the back checks capacity
// a word ending a block with a changed byte queues two pairs, which the back drains
// one at a time; the queue absorbs this, so the source stalls only under output stall
// synchronous active-low reset; capacity resets to its maximum
module byte_run_length_encoder_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_last_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_run_count,
    output logic [7:0]                 o_run_value,
    output logic                       o_overflow,
    output logic                       o_last_run,
    output logic [brle_pkg::CAP_W-1:0] o_bytes_written,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [brle_pkg::CAP_W-1:0] i_out_capacity
);

    brle_pkg::t_push push;
    brle_pkg::t_cmd  head;
    logic            head_vld;
    logic            pop;
    logic            full;
    logic            in_accept;

    assign o_in_stall  = full;
    assign in_accept   = i_in_valid && !full;
    assign o_cfg_ready = 1'b1;

    brle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push)
    );

    brle_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (pop),
        .o_head_vld (head_vld),
        .o_head     (head),
        .o_full     (full)
    );

    brle_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_out_capacity  (i_out_capacity),
        .i_head_vld      (head_vld),
        .i_head          (head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_run_count     (o_run_count),
        .o_run_value     (o_run_value),
        .o_overflow      (o_overflow),
        .o_last_run      (o_last_run),
        .o_bytes_written (o_bytes_written)
    );

endmodule

// File: test/tb_byte_run_length_encoder_top.sv
// testbench for the byte run-length encoder, result words checked against a run-length predictor
module tb_byte_run_length_encoder_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [brle_pkg::CAP_W-1:0] CAP_FULL       = '1;
    localparam int unsigned                WATCHDOG_LIMIT = 2000;
    localparam int unsigned                SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic [7:0]                 count;
        logic [7:0]                 value;
        logic                       ovf;
        logic                       last;
        logic [brle_pkg::CAP_W-1:0] bytes;
    } t_run_pair;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [7:0]                 i_data_byte;
    logic                       i_last_byte;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [7:0]                 o_run_count;
    logic [7:0]                 o_run_value;
    logic                       o_overflow;
    logic                       o_last_run;
    logic [brle_pkg::CAP_W-1:0] o_bytes_written;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [brle_pkg::CAP_W-1:0] i_out_capacity;

    t_run_pair   expected_pairs[$];
    int unsigned capacity      = 32'(CAP_FULL);
    logic        run_open      = 1'b0;
    logic [7:0]  run_val       = '0;
    logic [7:0]  run_len       = '0;
    int unsigned written       = 0;
    logic        blk_failed    = 1'b0;

    int unsigned send_gap_pct  = 0;
    int unsigned stall_pct     = 0;
    int unsigned idle_cycles   = 0;
    int unsigned mismatches    = 0;
    int unsigned words_sent    = 0;
    int unsigned pairs_seen    = 0;
    int unsigned overflows     = 0;
    int unsigned cfg_writes    = 0;

    byte_run_length_encoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_run_count     (o_run_count),
        .o_run_value     (o_run_value),
        .o_overflow      (o_overflow),
        .o_last_run      (o_last_run),
        .o_bytes_written (o_bytes_written),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_out_capacity  (i_out_capacity)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_block_state();
        run_open   = 1'b0;
        run_val    = '0;
        run_len    = '0;
        written    = 0;
        blk_failed = 1'b0;
    endfunction

    function automatic logic queue_pair(input logic [7:0] cnt, input logic [7:0] val,
                                        input logic lst);
        t_run_pair p;
        if (written + brle_pkg::PAIR_BYTES > capacity) begin
            p = '{count: '0, value: '0, ovf: 1'b1, last: 1'b1, bytes: '0};
            expected_pairs.insert(expected_pairs.size(), p);
            return 1'b0;
        end
        written = written + brle_pkg::PAIR_BYTES;
        p = '{count: cnt, value: val, ovf: 1'b0, last: lst,
              bytes: written[brle_pkg::CAP_W-1:0]};
        expected_pairs.insert(expected_pairs.size(), p);
        return 1'b1;
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic lst);
        logic ok;
        if (blk_failed) begin
            if (lst) clear_block_state();
            return;
        end
        if (run_open && b == run_val) begin
            run_len = run_len + 8'd1;
        end else begin
            if (run_open) begin
                if (!queue_pair(run_len, run_val, 1'b0)) begin
                    if (lst) clear_block_state();
                    else blk_failed = 1'b1;
                    return;
                end
            end
            run_open = 1'b1;
            run_val  = b;
            run_len  = 8'd1;
        end
        if (run_len >= brle_pkg::RUN_MAX || lst) begin
            ok       = queue_pair(run_len, run_val, lst);
            run_open = 1'b0;
            run_len  = '0;
            run_val  = '0;
            if (lst) clear_block_state();
            else if (!ok) blk_failed = 1'b1;
        end
    endfunction

    function automatic void check_pair();
        t_run_pair got;
        t_run_pair want;
        got = '{count: o_run_count, value: o_run_value, ovf: o_overflow, last: o_last_run,
                bytes: o_bytes_written};
        pairs_seen++;
        if (got.ovf) overflows++;
        if (expected_pairs.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word count %0d value %0h ovf %0b last %0b bytes %0d",
                     $time, got.count, got.value, got.ovf, got.last, got.bytes);
            return;
        end
        want = expected_pairs.pop_front();
        if (got.count !== want.count || got.value !== want.value || got.ovf !== want.ovf ||
            got.last !== want.last || got.bytes !== want.bytes) begin
            mismatches++;
            $display("%0t: expected count %0d value %0h ovf %0b last %0b bytes %0d", $time,
                     want.count, want.value, want.ovf, want.last, want.bytes);
            $display("%0t: actual   count %0d value %0h ovf %0b last %0b bytes %0d", $time,
                     got.count, got.value, got.ovf, got.last, got.bytes);
        end
    endfunction

    // monitor, predictor and watchdog share one process so their order per edge is fixed
    initial begin
        logic moved;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                moved = 1'b0;
                if (i_cfg_valid && o_cfg_ready) begin
                    capacity = 32'(i_out_capacity);
                    cfg_writes++;
                    moved = 1'b1;
                end
                if (i_in_valid && !o_in_stall) begin
                    encode_byte(i_data_byte, i_last_byte);
                    words_sent++;
                    moved = 1'b1;
                end
                if (o_out_valid && !i_out_stall) begin
                    check_pair();
                    moved = 1'b1;
                end
                if (moved) begin
                    idle_cycles = 0;
                end else begin
                    idle_cycles++;
                    if (idle_cycles >= WATCHDOG_LIMIT) begin
                        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                        $display("byte_run_length_encoder_top test failed");
                        $finish;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_pairs();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [brle_pkg::CAP_W-1:0] cap_value);
        drain_pairs();
        i_cfg_valid    <= 1'b1;
        i_out_capacity <= cap_value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_blocks();
        write_capacity(CAP_FULL);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    task automatic test_run_limit();
        int i;
        for (i = 0; i < 256; i++) send_byte(8'h77, i == 255);
        for (i = 0; i < 255; i++) send_byte(8'hC3, i == 254);
    endtask

    task automatic test_small_capacity();
        write_capacity('0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b1);
        write_capacity(20'd1);
        send_byte(8'hFF, 1'b1);
        write_capacity(20'd2);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b1);
        send_byte(8'h40, 1'b0);
        send_byte(8'h41, 1'b1);
        write_capacity(20'd4);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        // raised mid-block so the third pair fits
        write_capacity(20'd6);
        send_byte(8'h55, 1'b1);
        write_capacity(CAP_FULL);
    endtask

    task automatic test_random_blocks(input int unsigned words_per_phase);
        int unsigned phase;
        int unsigned sent;
        int unsigned len;
        int unsigned i;
        int unsigned kind;
        int unsigned change_pct;
        logic [7:0]  b;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_capacity(brle_pkg::CAP_W'($urandom_range(40, 8)));
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1: begin
                    write_capacity(brle_pkg::CAP_W'($urandom_range(24, 0)));
                    send_gap_pct = 73;
                    stall_pct    = 0;
                end
                2: begin
                    write_capacity(brle_pkg::CAP_W'($urandom));
                    send_gap_pct = 0;
                    stall_pct    = 73;
                end
                default: begin
                    write_capacity(CAP_FULL);
                    send_gap_pct = 8;
                    stall_pct    = 8;
                end
            endcase
            sent = 0;
            while (sent < words_per_phase) begin
                kind = $urandom_range(99);
                if (kind < 2) begin
                    len        = $urandom_range(270, 250);
                    change_pct = 1;
                end else begin
                    len        = $urandom_range(24, 1);
                    change_pct = 45;
                end
                b = 8'($urandom);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(99) < change_pct) begin
                        // narrow alphabet in most blocks so runs form
                        if (kind < 60) b = 8'($urandom_range(3));
                        else b = 8'($urandom);
                    end
                    send_byte(b, i == len - 1);
                end
                sent += len;
            end
        end
        send_gap_pct = 0;
        stall_pct    = 0;
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_data_byte    <= '0;
        i_last_byte    <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_out_capacity <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_blocks();
        test_run_limit();
        test_small_capacity();
        test_random_blocks(125);
        drain_pairs();

        $display("sent %0d source words, checked %0d result words (%0d overflows)",
                 words_sent, pairs_seen, overflows);
        $display("capacity written %0d times, from 0 up to full scale, under four idle mixes",
                 cfg_writes);
        if (mismatches == 0) begin
            $display("byte_run_length_encoder_top test passed");
        end else begin
            $display("byte_run_length_encoder_top test failed");
        end
        $finish;
    end

endmodule
